[design/mtg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mtg_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned NUM_WORDS = 624;
  localparam int unsigned TWIST_TAP = 397;
  localparam int unsigned CNT_W     = $clog2(NUM_WORDS);
  localparam int unsigned ADDR_W    = 3;

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

  localparam logic [CNT_W-1:0] SEED_LAST = CNT_W'(NUM_WORDS - 1);

  localparam logic REG_SEED = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEED = 2'b10
  } gen_state_e;

  function automatic logic [WORD_W-1:0] twist_word(
    input logic [WORD_W-1:0] w_cur,
    input logic [WORD_W-1:0] w_nxt,
    input logic [WORD_W-1:0] w_far
  );
    logic [WORD_W-1:0] y;
    y = {w_cur[WORD_W-1], w_nxt[WORD_W-2:0]};
    return w_far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
  endfunction

  function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [WORD_W-1:0] seed_word(
    input logic [WORD_W-1:0] prev,
    input logic [CNT_W-1:0]  k
  );
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] p;
    x = prev ^ (prev >> 30);
    p = WORD_W'(x * SEED_MULT);
    return p + {{(WORD_W-CNT_W){1'b0}}, k};
  endfunction

endpackage

`default_nettype wire

[design/mtg_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module mtg_cell
  import mtg_pkg::*;
#(
  parameter int unsigned Width = WORD_W
) (
  input  wire logic             clk_i,
  input  wire logic             shift_i,
  input  wire logic [Width-1:0] word_i,
  output logic      [Width-1:0] word_o
);

  logic [Width-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

[design/mersenne_twister_generator.sv]
`timescale 1ns / 1ps
`default_nettype none

// MT19937 generator. Each request on the input channel (in_valid_i/in_ready_o,
// with the reseed_i flag) returns one tempered 32-bit word on value_o, with its
// low 24 bits on fraction_o, through the output channel (out_valid_o/out_ready_i).
// The state lives in a row of 624 word cells that shift toward the head. Each
// produced word is twisted from the head, the next cell and cell 397, shifted in
// at the tail, and tempered into the output register.
// A request without seeding is held in the input register until the output register
// is free and its result is then registered there. One request per cycle is
// sustained while the receiver takes results.
// The first request after reset, or one with reseed_i set, first refills the row
// from the seed register, one word per cycle through the seeding multiplier.
// Reset clears the control state and sets the seed register to 5489; the cells
// hold no value until seeding. When the receiver stalls, the result waits in the
// output register and one more request is still taken into the input register.
// The seed register is written and read over the APB port at byte addresses 0 to 3.

module mersenne_twister_generator
  import mtg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              reseed_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [WORD_W-1:0] value_o,
  output logic      [FRAC_W-1:0] fraction_o
);

  logic [WORD_W-1:0] seed_q;
  logic              req_valid_q, req_valid_d;
  logic              req_reseed_q, req_reseed_d;
  logic              seeded_q, seeded_d;
  gen_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] value_q;

  logic              start_seed;
  logic              gen_fire;
  logic              shift;
  logic [WORD_W-1:0] tail_word;
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] words [NUM_WORDS];

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_SEED) ? seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_SEED) begin
      seed_q <= pwdata;
    end
  end

  for (genvar k = 0; k < NUM_WORDS; k++) begin : g_cell
    if (k == NUM_WORDS - 1) begin : g_tail
      mtg_cell #(.Width(WORD_W)) u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .word_i (tail_word),
        .word_o (words[k])
      );
    end else begin : g_body
      mtg_cell #(.Width(WORD_W)) u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .word_i (words[k+1]),
        .word_o (words[k])
      );
    end
  end

  assign new_word = twist_word(words[0], words[1], words[TWIST_TAP]);

  assign start_seed = req_valid_q && (state_q == ST_IDLE) && (req_reseed_q || !seeded_q);
  assign gen_fire   = req_valid_q && (state_q == ST_IDLE) && seeded_q && !req_reseed_q
                      && (!out_valid_q || out_ready_i);
  assign shift      = start_seed || (state_q == ST_SEED) || gen_fire;
  assign in_ready_o = !req_valid_q || gen_fire;

  always_comb begin
    tail_word = new_word;
    if (start_seed) begin
      tail_word = seed_q;
    end else if (state_q == ST_SEED) begin
      tail_word = seed_word(words[NUM_WORDS-1], cnt_q);
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    seeded_d     = seeded_q;
    req_valid_d  = req_valid_q;
    req_reseed_d = req_reseed_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (gen_fire) begin
      out_valid_d = 1'b1;
      req_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      req_valid_d  = 1'b1;
      req_reseed_d = reseed_i;
    end
    case (state_q)
      ST_IDLE: begin
        if (start_seed) begin
          state_d = ST_SEED;
          cnt_d   = CNT_W'(1);
        end
      end
      ST_SEED: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == SEED_LAST) begin
          state_d      = ST_IDLE;
          seeded_d     = 1'b1;
          req_reseed_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      seeded_q     <= 1'b0;
      req_valid_q  <= 1'b0;
      req_reseed_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      seeded_q     <= seeded_d;
      req_valid_q  <= req_valid_d;
      req_reseed_q <= req_reseed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_fire) begin
      value_q <= temper_word(new_word);
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign fraction_o  = value_q[FRAC_W-1:0];

  a_seed_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED) |-> (cnt_q != '0) && (cnt_q <= SEED_LAST))
    else $error("Seed counter out of range.");

  a_seed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED) && (cnt_q == SEED_LAST)
    |=> (state_q == ST_IDLE) && seeded_q && req_valid_q && !req_reseed_q)
    else $error("Seeding did not hand back to the pending request.");

  a_result_after_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_IDLE) && $past(seeded_q))
    else $error("Result produced from unseeded state.");

  a_no_accept_seeding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED) |-> !gen_fire && !(in_valid_i && in_ready_o))
    else $error("Request taken during seeding.");

endmodule

`default_nettype wire

[sim/mersenne_twister_generator_tb.sv]
`timescale 1ns / 1ps

module mersenne_twister_generator_tb;
  import mtg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned NUM_PHASES  = 5;
  localparam int unsigned NUM_ROWS    = 20;
  localparam logic [ADDR_W-1:0] SEED_ADDR = ADDR_W'({REG_SEED, 2'b00});

  typedef struct {
    logic [WORD_W-1:0] value;
    logic [FRAC_W-1:0] fraction;
  } word_res_t;

  typedef struct {
    bit                write_seed;
    logic [WORD_W-1:0] seed;
    bit                reseed;
    bit                known;
    logic [WORD_W-1:0] word;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              reseed_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [WORD_W-1:0] value_o;
  logic [FRAC_W-1:0] fraction_o;

  mersenne_twister_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .reseed_i   (reseed_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .fraction_o (fraction_o)
  );

  logic [WORD_W-1:0] pred_words [NUM_WORDS];
  int unsigned       pred_pos;
  bit                pred_seeded;
  logic [WORD_W-1:0] pred_seed;
  word_res_t         word_q [$];

  int unsigned err_count;
  int unsigned cycle_cnt;
  int unsigned req_count;
  int unsigned refill_count;
  int unsigned regen_count;
  int unsigned seed_count;
  bit          no_idle;
  bit          long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, word_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void note_mismatch(input string what, input logic [WORD_W-1:0] exp_v,
                                        input logic [WORD_W-1:0] act_v);
    err_count++;
    if (err_count <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, exp_v, act_v);
    end
  endfunction

  function automatic void refill_from_seed();
    logic [WORD_W-1:0] p;
    pred_words[0] = pred_seed;
    for (int unsigned k = 1; k < NUM_WORDS; k++) begin
      p = pred_words[k-1];
      pred_words[k] = SEED_MULT * (p ^ (p >> 30)) + WORD_W'(k);
    end
    pred_pos = NUM_WORDS;
    pred_seeded = 1'b1;
    refill_count++;
  endfunction

  function automatic void regenerate_words();
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] mix;
    int unsigned       nxt;
    int unsigned       far;
    for (int unsigned k = 0; k < NUM_WORDS; k++) begin
      nxt = (k + 1) % NUM_WORDS;
      far = (k + TWIST_TAP) % NUM_WORDS;
      y = {pred_words[k][WORD_W-1], pred_words[nxt][WORD_W-2:0]};
      mix = y[0] ? TWIST_MATRIX : {WORD_W{1'b0}};
      pred_words[k] = pred_words[far] ^ (y >> 1) ^ mix;
    end
    pred_pos = 0;
    regen_count++;
  endfunction

  function automatic logic [WORD_W-1:0] scramble_out(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  function automatic logic [WORD_W-1:0] next_word(input bit rs);
    logic [WORD_W-1:0] w;
    if (rs || !pred_seeded) refill_from_seed();
    if (pred_pos >= NUM_WORDS) regenerate_words();
    w = scramble_out(pred_words[pred_pos]);
    pred_pos++;
    return w;
  endfunction

  task automatic send_req(input bit rs, input bit known, input logic [WORD_W-1:0] kword);
    logic [WORD_W-1:0] w;
    word_res_t         r;
    while (!no_idle && $urandom_range(0, 99) < 15) begin
      in_valid_i = 1'b0;
      reseed_i = $urandom_range(0, 1);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    reseed_i = rs;
    do @(posedge clk_i); while (!in_ready_o);
    w = next_word(rs);
    if (known) w = kword;
    r.value = w;
    r.fraction = w[FRAC_W-1:0];
    word_q.push_back(r);
    req_count++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (word_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_read_check();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = SEED_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== pred_seed) note_mismatch("seed readback", pred_seed, prdata);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_seed(input logic [WORD_W-1:0] v);
    drain();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = SEED_ADDR;
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    pred_seed = v;
    seed_count++;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    pwdata = $urandom;
    apb_read_check();
  endtask

  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold != 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else begin
        out_ready_i = no_idle || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  initial begin : result_check
    word_res_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (word_q.size() == 0) begin
          note_mismatch("unexpected result value", '0, value_o);
        end else begin
          exp_r = word_q.pop_front();
          if (value_o !== exp_r.value) note_mismatch("value", exp_r.value, value_o);
          if (fraction_o !== exp_r.fraction) begin
            note_mismatch("fraction", WORD_W'(exp_r.fraction), WORD_W'(fraction_o));
          end
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t          rows [NUM_ROWS];
    logic [WORD_W-1:0] phase_seed [NUM_PHASES];
    int unsigned       phase_len [NUM_PHASES];
    int unsigned       phase_pct [NUM_PHASES];
    bit                rs;

    rows = '{
      '{1'b0, 32'h0000_0000, 1'b0, 1'b1, 32'd3499211612},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b1, 32'd581869302},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b1, 32'd3499211612},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b1, 32'd581869302},
      '{1'b1, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b1, 32'hffff_ffff, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
      '{1'b1, 32'd5489,      1'b1, 1'b1, 32'd3499211612},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b1, 32'd581869302},
      '{1'b1, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
      '{1'b1, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
      '{1'b1, 32'h7fff_ffff, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b1, 32'ha5a5_5a5a, 1'b1, 1'b0, 32'h0}
    };
    phase_seed = '{$urandom, 32'h0000_0000, 32'hffff_ffff, $urandom, $urandom};
    phase_len  = '{300, 700, 300, 300, 300};
    phase_pct  = '{3, 0, 2, 5, 2};

    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    reseed_i = 1'b0;
    out_ready_i = 1'b0;
    pred_pos = NUM_WORDS;
    pred_seeded = 1'b0;
    pred_seed = SEED_RESET;
    foreach (pred_words[k]) pred_words[k] = '0;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    apb_read_check();

    foreach (rows[i]) begin
      if (rows[i].write_seed) set_seed(rows[i].seed);
      send_req(rows[i].reseed, rows[i].known, rows[i].word);
    end

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      set_seed(phase_seed[p]);
      no_idle = (p == 2);
      for (int unsigned n = 0; n < phase_len[p]; n++) begin
        rs = (n == 0) || ($urandom_range(0, 99) < phase_pct[p]);
        if (p == 0 && n == 100) long_hold_req = 1'b1;
        if (p == 3 && n == 150) drain();
        send_req(rs, 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    in_valid_i = 1'b0;
    while (word_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (word_q.size() != 0) note_mismatch("results left over", '0, WORD_W'(word_q.size()));

    $display("Covered %0d requests over %0d seed settings, %0d state refills from the seed,",
             req_count, seed_count, refill_count);
    $display("and %0d full regenerations of the state; %0d failures.", regen_count, err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
